### rtl/u2j_pkg.sv
package u2j_pkg;

  // One input beat: a source byte and the end-of-string mark.
  typedef struct packed {
    logic [7:0] in_byte;
    logic       is_final;
  } u2j_byte_t;

  // One result beat: an escaped ASCII character and the end-of-run mark.
  typedef struct packed {
    logic [6:0] out_char;
    logic       last_of_run;
  } u2j_char_t;

  // How a finished code point is written out.
  typedef enum logic [1:0] {
    JOB_RAW,    // one character as it is
    JOB_SHORT,  // backslash and a letter
    JOB_UNI,    // one \uXXXX escape
    JOB_PAIR    // two \uXXXX escapes, high then low surrogate
  } u2j_kind_t;

  // A classified code point as it waits for the back end.
  typedef struct packed {
    u2j_kind_t   kind;
    logic [6:0]  ch;       // raw character or short escape letter
    logic [15:0] unit_hi;  // first (or only) UTF-16 unit
    logic [15:0] unit_lo;  // low surrogate
  } u2j_job_t;

  localparam logic [6:0] CH_BSLASH = 7'h5C;
  localparam logic [6:0] CH_U      = 7'h75;

  // Letter of the two-character escape, or zero when the point has none.
  function automatic logic [6:0] short_letter(input logic [20:0] cp);
    logic [6:0] r;
    r = 7'h00;
    case (cp)
      21'h08:  r = 7'h62;  // b
      21'h0C:  r = 7'h66;  // f
      21'h0A:  r = 7'h6E;  // n
      21'h0D:  r = 7'h72;  // r
      21'h09:  r = 7'h74;  // t
      21'h22:  r = 7'h22;  // quote
      21'h5C:  r = 7'h5C;  // backslash
      default: r = 7'h00;
    endcase
    return r;
  endfunction

  // Upper-case hex digit.
  function automatic logic [6:0] hex_char(input logic [3:0] nib);
    logic [6:0] r;
    if (nib < 4'd10) begin
      r = 7'h30 + {3'b000, nib};
    end else begin
      r = 7'h37 + {3'b000, nib};
    end
    return r;
  endfunction

endpackage

### rtl/u2j_front.sv
module u2j_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  u2j_pkg::u2j_byte_t byte_item,
  input  logic               job_full,
  output logic               job_push,
  output u2j_pkg::u2j_job_t  job
);
  import u2j_pkg::*;

  logic [1:0]  bytes_pending;
  logic [20:0] code_accum;
  logic [1:0]  bytes_pending_next;
  logic [20:0] code_accum_next;

  logic        accept;
  logic        drop;
  logic        emit;
  logic [1:0]  pend_new;
  logic [20:0] cp;
  logic [20:0] cp_off;
  logic [6:0]  letter;
  logic [7:0]  b;

  assign full   = job_full;
  assign accept = push && !job_full;
  assign b      = byte_item.in_byte;

  // Decode the lead byte or fold in a continuation byte.
  always_comb begin
    drop     = 1'b0;
    pend_new = 2'd0;
    cp       = 21'd0;
    if (bytes_pending != 2'd0) begin
      cp       = {code_accum[14:0], b[5:0]};
      pend_new = bytes_pending - 2'd1;
    end else if (!b[7]) begin
      cp = {13'd0, b};
    end else if (!b[6]) begin
      cp = {14'd0, b[6:0]};
    end else if (!b[5]) begin
      cp       = {16'd0, b[4:0]};
      pend_new = 2'd1;
    end else if (!b[4]) begin
      cp       = {17'd0, b[3:0]};
      pend_new = 2'd2;
    end else if (!b[3]) begin
      cp       = {18'd0, b[2:0]};
      pend_new = 2'd3;
    end else begin
      drop = 1'b1;
    end
  end

  // The point is complete when nothing more is expected or the string ends.
  assign emit     = !drop && ((pend_new == 2'd0) || byte_item.is_final);
  assign job_push = accept && emit;

  always_comb begin
    bytes_pending_next = bytes_pending;
    code_accum_next    = code_accum;
    if (accept && !drop) begin
      if (emit) begin
        bytes_pending_next = 2'd0;
        code_accum_next    = 21'd0;
      end else begin
        bytes_pending_next = pend_new;
        code_accum_next    = cp;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_pending <= 2'd0;
      code_accum    <= 21'd0;
    end else begin
      bytes_pending <= bytes_pending_next;
      code_accum    <= code_accum_next;
    end
  end

  // Classify the finished point for the back end.
  assign letter = short_letter(cp);
  assign cp_off = cp - 21'h10000;

  always_comb begin
    job.ch      = cp[6:0];
    job.unit_hi = cp[15:0];
    job.unit_lo = {6'b110111, cp[9:0]};
    if (letter != 7'h00) begin
      job.kind = JOB_SHORT;
      job.ch   = letter;
    end else if (cp < 21'h80) begin
      job.kind = JOB_RAW;
    end else if (cp[20:16] == 5'd0) begin
      job.kind = JOB_UNI;
    end else begin
      job.kind    = JOB_PAIR;
      job.unit_hi = 16'hD800 + {5'd0, cp_off[20:10]};
    end
  end

endmodule

### rtl/u2j_queue.sv
module u2j_queue #(
  parameter int DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  u2j_pkg::u2j_job_t wr_job,
  output logic              q_full,
  input  logic              rd_en,
  output u2j_pkg::u2j_job_t rd_job,
  output logic              q_empty
);
  import u2j_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  u2j_job_t        slots [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;

  assign q_full  = (count == CW'(DEPTH));
  assign q_empty = (count == '0);
  assign rd_job  = slots[rd_ptr];

  // Storage is written only; no reset needed.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_job;
    end
  end

  // Pointers and occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (wr_en && !rd_en) begin
        count <= count + CW'(1);
      end else if (rd_en && !wr_en) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

### rtl/u2j_back.sv
module u2j_back (
  input  logic               clk,
  input  logic               rst,
  input  u2j_pkg::u2j_job_t  job,
  input  logic               job_empty,
  output logic               job_pop,
  output logic               empty,
  input  logic               pop,
  output u2j_pkg::u2j_char_t char_item
);
  import u2j_pkg::*;

  logic [3:0]  idx;
  logic [3:0]  idx_next;
  logic        out_valid;
  logic        out_valid_next;
  u2j_char_t   out_reg;
  u2j_char_t   out_reg_next;

  logic        advance;
  logic [3:0]  len_m1;
  logic        at_last;
  logic        sel_lo;
  logic [3:0]  pos;
  logic [15:0] unit;
  logic [6:0]  ch;

  assign empty     = !out_valid;
  assign char_item = out_reg;

  // Step to the next character when one is queued and the output slot frees.
  assign advance = !job_empty && (!out_valid || pop);

  always_comb begin
    case (job.kind)
      JOB_RAW:   len_m1 = 4'd0;
      JOB_SHORT: len_m1 = 4'd1;
      JOB_UNI:   len_m1 = 4'd5;
      JOB_PAIR:  len_m1 = 4'd11;
      default:   len_m1 = 4'd0;
    endcase
  end

  assign at_last = (idx == len_m1);
  assign job_pop = advance && at_last;

  // Pick the character at the current place in the run.
  assign sel_lo = (idx >= 4'd6);
  assign pos    = sel_lo ? idx - 4'd6 : idx;
  assign unit   = sel_lo ? job.unit_lo : job.unit_hi;

  always_comb begin
    ch = CH_BSLASH;
    case (job.kind)
      JOB_RAW: begin
        ch = job.ch;
      end
      JOB_SHORT: begin
        ch = (idx == 4'd0) ? CH_BSLASH : job.ch;
      end
      default: begin
        case (pos)
          4'd0:    ch = CH_BSLASH;
          4'd1:    ch = CH_U;
          4'd2:    ch = hex_char(unit[15:12]);
          4'd3:    ch = hex_char(unit[11:8]);
          4'd4:    ch = hex_char(unit[7:4]);
          default: ch = hex_char(unit[3:0]);
        endcase
      end
    endcase
  end

  always_comb begin
    idx_next       = idx;
    out_valid_next = out_valid;
    out_reg_next   = out_reg;
    if (advance) begin
      out_valid_next           = 1'b1;
      out_reg_next.out_char    = ch;
      out_reg_next.last_of_run = at_last;
      idx_next                 = at_last ? 4'd0 : idx + 4'd1;
    end else if (pop) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= 4'd0;
      out_valid <= 1'b0;
    end else begin
      idx       <= idx_next;
      out_valid <= out_valid_next;
    end
  end

  // Result beat register; the payload needs no reset.
  always_ff @(posedge clk) begin
    out_reg <= out_reg_next;
  end

endmodule

### rtl/utf8_to_json_string_escaper.sv
// UTF-8 to JSON string escaper. Source bytes enter one beat at a time and
// leave as the ASCII characters of the JSON-escaped text, one character per
// result beat, with last_of_run set on the final character a byte causes.
// The front end gathers a code point and classifies it in the cycle the byte
// is accepted; bytes that end no point cause no result. Each finished point
// waits in a QUEUE_DEPTH-entry job queue, and the back end writes it out at
// one character per cycle while the receiver pops: one character for plain
// ASCII, two for a short escape, six for \uXXXX and twelve for a surrogate
// pair. Throughput is therefore one byte per cycle while the characters
// produced keep pace with the bytes consumed, and otherwise it is set by the
// back end's one-character-per-cycle output; full rises when the job queue
// holds QUEUE_DEPTH points. A byte's job goes into the queue, and the output
// register then takes its first character and drives the result ports.
module utf8_to_json_string_escaper #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  u2j_pkg::u2j_byte_t byte_item,
  output logic               empty,
  input  logic               pop,
  output u2j_pkg::u2j_char_t char_item
);
  import u2j_pkg::*;

  u2j_job_t job_in;
  u2j_job_t job_out;
  logic     job_push;
  logic     job_pop;
  logic     job_full;
  logic     job_empty;

  // Decode and classify.
  u2j_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .byte_item (byte_item),
    .job_full  (job_full),
    .job_push  (job_push),
    .job       (job_in)
  );

  // Decoupling queue of classified points.
  u2j_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (job_push),
    .wr_job  (job_in),
    .q_full  (job_full),
    .rd_en   (job_pop),
    .rd_job  (job_out),
    .q_empty (job_empty)
  );

  // Character sequencer and output register.
  u2j_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job       (job_out),
    .job_empty (job_empty),
    .job_pop   (job_pop),
    .empty     (empty),
    .pop       (pop),
    .char_item (char_item)
  );

endmodule

### tb/sv/tb_utf8_to_json_string_escaper.sv
`timescale 1ns / 100ps

module tb_utf8_to_json_string_escaper;
  import u2j_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 200;
  localparam int DRAIN_CYCLES = 24;
  localparam int REPORT_MAX = 10;

  logic      clk;
  logic      rst;
  logic      push;
  logic      full;
  u2j_byte_t byte_item;
  logic      empty;
  logic      pop;
  u2j_char_t char_item;

  // Predicted character beats, oldest first.
  u2j_char_t expected_chars[$];

  // Decoder state mirrored from the block.
  logic [1:0]  cont_left  = 2'd0;
  logic [20:0] point_bits = 21'd0;

  // Traffic shaping shared by sender and receiver.
  bit idle_on  = 1'b1;
  bit hold_pop = 1'b0;

  int unsigned bytes_sent        = 0;
  int unsigned chars_checked     = 0;
  int unsigned bad_beats         = 0;
  int unsigned full_stall_cycles = 0;
  int unsigned cycle_count       = 0;

  utf8_to_json_string_escaper i_dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .byte_item (byte_item),
    .empty     (empty),
    .pop       (pop),
    .char_item (char_item)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Letter of the two-character escape, or zero when the point has none.
  function automatic logic [7:0] escape_letter(input logic [20:0] cp);
    case (cp)
      21'h08:  return "b";
      21'h0C:  return "f";
      21'h0A:  return "n";
      21'h0D:  return "r";
      21'h09:  return "t";
      21'h22:  return "\"";
      21'h5C:  return "\\";
      default: return 8'd0;
    endcase
  endfunction

  function automatic logic [6:0] hex_digit_of(input logic [3:0] nib);
    logic [7:0] c;
    if (nib < 4'd10) begin
      c = "0" + nib;
    end else begin
      c = "A" + nib - 8'd10;
    end
    return c[6:0];
  endfunction

  function automatic void queue_char(input logic [6:0] c);
    u2j_char_t beat;
    beat.out_char    = c;
    beat.last_of_run = 1'b0;
    expected_chars.push_back(beat);
  endfunction

  function automatic void queue_u_escape(input logic [15:0] unit);
    queue_char(CH_BSLASH);
    queue_char(CH_U);
    for (int i = 3; i >= 0; i--) begin
      queue_char(hex_digit_of(unit[4*i +: 4]));
    end
  endfunction

  // Expand one finished code point into its escaped characters.
  function automatic void queue_point(input logic [20:0] cp);
    logic [7:0]  letter;
    logic [20:0] above_bmp;
    u2j_char_t   tail;
    letter = escape_letter(cp);
    if (letter != 8'd0) begin
      queue_char(CH_BSLASH);
      queue_char(letter[6:0]);
    end else if (cp < 21'h80) begin
      queue_char(cp[6:0]);
    end else if (cp <= 21'hFFFF) begin
      queue_u_escape(cp[15:0]);
    end else begin
      // Surrogate pair; points past the Unicode range still split this way.
      above_bmp = cp - 21'h10000;
      queue_u_escape(16'hD800 + {5'd0, above_bmp[20:10]});
      queue_u_escape({6'b110111, cp[9:0]});
    end
    tail = expected_chars.pop_back();
    tail.last_of_run = 1'b1;
    expected_chars.push_back(tail);
  endfunction

  // Step the mirrored decoder by one accepted source byte.
  function automatic void escape_byte(input logic [7:0] b, input logic fin);
    int unsigned lead_ones;
    logic [20:0] cp;
    lead_ones = 0;
    if (cont_left == 2'd0) begin
      while (lead_ones < 8 && b[7 - lead_ones]) begin
        lead_ones++;
      end
      // Leads of five or more ones are dropped outright.
      if (lead_ones >= 5) begin
        return;
      end
      if (lead_ones == 0) begin
        cp = {13'd0, b};
      end else begin
        // A stray continuation byte lands here with nothing pending.
        cp = {13'd0, b & (8'hFF >> lead_ones)};
        cont_left = 2'(lead_ones - 1);
      end
    end else begin
      // Whatever byte arrives here counts as a continuation.
      cp = {point_bits[14:0], b[5:0]};
      cont_left = cont_left - 2'd1;
    end
    if (cont_left != 2'd0 && !fin) begin
      point_bits = cp;
      return;
    end
    // Complete point, or a sequence cut short by the end of the string.
    cont_left  = 2'd0;
    point_bits = 21'd0;
    queue_point(cp);
  endfunction

  // Offer one source byte and hold it until the block takes it.
  task automatic send_byte(input logic [7:0] b, input logic fin);
    u2j_byte_t beat;
    beat.in_byte  = b;
    beat.is_final = fin;
    while (idle_on && $urandom_range(99) < 8) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push      <= 1'b1;
    byte_item <= beat;
    @(posedge clk);
    while (full) begin
      @(posedge clk);
    end
    escape_byte(b, fin);
    bytes_sent++;
  endtask

  // Send the first n_sent bytes of a len-byte UTF-8 sequence with random payload.
  task automatic send_utf8_seq(input int unsigned len, input int unsigned n_sent,
                               input int unsigned final_pct);
    logic [7:0] b;
    logic       fin;
    for (int unsigned i = 0; i < n_sent; i++) begin
      if (i == 0) begin
        b = 8'((8'hFF << (8 - len)) | $urandom_range(0, (1 << (7 - len)) - 1));
      end else begin
        b = 8'h80 | 8'($urandom_range(0, 63));
      end
      fin = ($urandom_range(99) < 3) || (i == n_sent - 1 && $urandom_range(99) < final_pct);
      send_byte(b, fin);
    end
  endtask

  // Plain ASCII extremes and every two-character escape.
  task automatic test_plain_and_short_escapes();
    send_byte(8'h00, 1'b0);
    send_byte(8'h7F, 1'b1);
    send_byte(8'h08, 1'b0);
    send_byte(8'h0C, 1'b0);
    send_byte(8'h0A, 1'b0);
    send_byte(8'h0D, 1'b0);
    send_byte(8'h09, 1'b0);
    send_byte(8'h22, 1'b0);
    send_byte(8'h5C, 1'b1);
  endtask

  // Multi-byte points, odd leads and broken sequences.
  task automatic test_multibyte_and_odd_leads();
    // Two-byte point and the top of the basic plane.
    send_byte(8'hC3, 1'b0);
    send_byte(8'hA9, 1'b0);
    send_byte(8'hEF, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b0);
    // Largest four-byte value, well past the Unicode range.
    send_byte(8'hF7, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b1);
    // Stray continuation byte whose low bits are a quote.
    send_byte(8'hA2, 1'b0);
    // Over-long leads are dropped, also when they end the string.
    send_byte(8'hF8, 1'b0);
    send_byte(8'hFF, 1'b1);
    // Three-byte sequence cut short by the end of the string.
    send_byte(8'hE2, 1'b0);
    send_byte(8'h82, 1'b1);
    // ASCII byte taken as a continuation.
    send_byte(8'hC3, 1'b0);
    send_byte(8'h41, 1'b0);
  endtask

  // Stop the receiver while four-byte points pour in, so the block fills up.
  task automatic test_full_backpressure();
    hold_pop = 1'b1;
    for (int k = 0; k < 8; k++) begin
      send_utf8_seq(4, 4, 0);
    end
  endtask

  // Mostly well-formed text with random content, plus noise and broken sequences.
  task automatic test_random_stream(input int unsigned n_items);
    int unsigned start_count;
    int unsigned done;
    int unsigned pick;
    int unsigned len;
    logic [7:0]  b;
    start_count = bytes_sent;
    done = 0;
    while (done < n_items) begin
      // A stretch in the middle runs with no idling on either side.
      idle_on = !(done >= n_items / 3 && done < n_items / 3 + 80);
      pick = $urandom_range(99);
      if (pick < 30) begin
        if ($urandom_range(3) == 0) begin
          case ($urandom_range(6))
            0:       b = 8'h08;
            1:       b = 8'h0C;
            2:       b = 8'h0A;
            3:       b = 8'h0D;
            4:       b = 8'h09;
            5:       b = 8'h22;
            default: b = 8'h5C;
          endcase
        end else begin
          b = 8'($urandom_range(0, 127));
        end
        send_byte(b, $urandom_range(99) < 5);
      end else if (pick < 50) begin
        send_utf8_seq(2, 2, 5);
      end else if (pick < 65) begin
        send_utf8_seq(3, 3, 5);
      end else if (pick < 80) begin
        send_utf8_seq(4, 4, 5);
      end else if (pick < 90) begin
        send_byte(8'($urandom_range(0, 255)), $urandom_range(99) < 5);
      end else begin
        len = $urandom_range(2, 4);
        send_utf8_seq(len, $urandom_range(1, len - 1), 50);
      end
      done = bytes_sent - start_count;
    end
    idle_on = 1'b1;
  endtask

  // Receiver: random pop idling, and a long counted hold-off on request.
  initial begin
    pop <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_pop) begin
        pop <= 1'b0;
        for (int n = 1; n < HOLD_CYCLES; n++) begin
          @(posedge clk);
        end
        hold_pop = 1'b0;
      end else begin
        pop <= !idle_on || ($urandom_range(99) >= 8);
      end
    end
  end

  // Compare each accepted character beat with the oldest prediction.
  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      if (expected_chars.size() == 0) begin
        bad_beats++;
        if (bad_beats <= REPORT_MAX) begin
          $display("ERROR: unexpected beat char %h last %b", char_item.out_char,
                   char_item.last_of_run);
        end
      end else begin
        if (char_item.out_char != expected_chars[0].out_char ||
            char_item.last_of_run != expected_chars[0].last_of_run) begin
          bad_beats++;
          if (bad_beats <= REPORT_MAX) begin
            $display("ERROR: beat %0d expected char %h last %b, got char %h last %b",
                     chars_checked, expected_chars[0].out_char,
                     expected_chars[0].last_of_run, char_item.out_char,
                     char_item.last_of_run);
          end
        end
        void'(expected_chars.pop_front());
      end
      chars_checked++;
    end
  end

  // Cycle count and input stalls seen while the block is full.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (!rst && push && full) begin
      full_stall_cycles <= full_stall_cycles + 1;
    end
  end

  // Watchdog against a hung handshake.
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("simulation failed");
    $finish;
  end

  initial begin
    rst       <= 1'b1;
    push      <= 1'b0;
    byte_item <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_plain_and_short_escapes();
    test_multibyte_and_odd_leads();
    test_full_backpressure();
    test_random_stream(300);

    push <= 1'b0;
    while (expected_chars.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Fed %0d source bytes and checked %0d escaped characters.", bytes_sent,
             chars_checked);
    $display("Input stalled on a full block for %0d cycles; %0d beats were wrong.",
             full_stall_cycles, bad_beats);
    if (bad_beats == 0 && expected_chars.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
